### rtl/ljpf_pkg.sv
// Shared types, constants and register codes for the Lennard-Jones pair force pipeline.
// No dependencies; imported by ljpf_qmul and lennard_jones_pair_force.
package ljpf_pkg;

  // Pipeline geometry.
  localparam int unsigned DIV_STAGES = 32;  // two quotient bits per stage, 64 bits in all
  localparam int unsigned N_SIDE     = 45;  // sideband stages from range check to final stage
  localparam int unsigned N_VLD      = 48;  // valid bits ahead of the output register

  // Q32.32 magnitudes; the all-ones value stands for infinity.
  localparam logic [63:0] QSAT      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_HALF    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Q_ONE     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] FORCE_LIM = 64'h0000_8000_0000_0000;

  localparam logic [47:0]        OUT_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [57:0] E_MAX     = 58'sd140737488355327;
  localparam logic signed [57:0] E_MIN     = -58'sd140737488355328;
  localparam logic signed [33:0] FAR_DELTA = 34'sd16777216;

  localparam logic [47:0] PAIR_RESET   = 48'h0100_0100_0000;
  localparam logic [31:0] BOX_RESET    = 32'd655360;
  localparam logic [31:0] CUTOFF_RESET = 32'd409600;

  typedef enum logic [2:0] {
    REG_PAIR_SAME_ONE,
    REG_PAIR_SAME_TWO,
    REG_PAIR_MIXED,
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_CUTOFF_SQ
  } cfg_reg_t;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic             ta;
    logic             tb;
    logic             inr;
    logic [2:0][24:0] d;
    logic [15:0]      eps;
    logic [15:0]      shift;
  } side_t;

  // State of the restoring divider between stages.
  typedef struct packed {
    logic [47:0] rem;
    logic [7:0]  nb;
    logic [63:0] q;
    logic [47:0] r2;
    logic        sat;
    logic        zero;
  } div_t;

endpackage

### rtl/lennard_jones_pair_force.sv
// Top level of the Lennard-Jones 12-6 pair force pipeline.
// Depends on ljpf_pkg and ljpf_qmul.
//
// Each input item is a pair of particles (type and unsigned Q16.16 position); each item
// gives exactly one result item holding the force on the first particle and the shifted
// pair energy, both signed Q24.24 and saturated, plus an in-range flag. Deltas are wrapped
// once by the box length, the squared distance is compared with the cutoff, and the
// parameters are picked by type pair. Force is only produced for a type-1 particle against
// a type-2 partner. The pipeline takes one item every clock cycle while it is not held;
// its depth is set mostly by the 32-stage restoring divider that forms sigma squared over
// r squared, two quotient bits a stage, followed by four rounds of two-stage multipliers.
// The whole pipeline advances together whenever the output register is empty or being
// taken; a one-item skid register at the input lets an item be accepted while a finished
// result still waits at the output.
// Configuration writes are always taken at once and must only be made while the block
// holds no items in flight.
module lennard_jones_pair_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               a_type,
  input  logic               b_type,
  input  logic [31:0]        a_x,
  input  logic [31:0]        a_y,
  input  logic [31:0]        a_z,
  input  logic [31:0]        b_x,
  input  logic [31:0]        b_y,
  input  logic [31:0]        b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic signed [47:0] pair_energy,
  output logic               in_range
);
  import ljpf_pkg::*;

  // Configuration registers.
  logic [47:0]      pair_same_one, pair_same_two, pair_mixed;
  logic [2:0][31:0] box;
  logic [31:0]      cutoff_sq;

  // Global advance and valid tracking.
  logic             en;
  logic [N_VLD-1:0] vld;

  // Input skid register.
  logic             skid_v;
  logic             sk_ta, sk_tb;
  logic [2:0][31:0] sk_a, sk_b;
  logic             src_v, src_ta, src_tb;
  logic [2:0][31:0] src_a, src_b;

  // Front stages: wrap, square, range check.
  logic             s1_ta, s1_tb;
  logic [2:0][33:0] s1_d;
  logic [2:0]       s1_ge, s1_le;
  logic [2:0][33:0] diff_c;
  logic [2:0]       ge_c, le_c;
  logic             s2_ta, s2_tb;
  logic [2:0][33:0] s2_d, dw_c;
  logic             s3_ta, s3_tb, s3_far;
  logic [2:0][47:0] s3_sq;
  logic [2:0][24:0] s3_d;
  logic [2:0]       far_c;
  logic [2:0][47:0] sq_c;
  logic [49:0]      r2_c;
  logic [47:0]      prm_c;
  logic [47:0]      r2_4;
  logic [15:0]      sig2_4;

  side_t sdl [N_SIDE];
  div_t  div [DIV_STAGES+1];

  // Back end: products and output forming.
  logic [63:0] r2i0, r2i1, r2i2, a1, t1, t1_3, t1_4, r6i, t2, e4r6, ff, en8;
  logic [63:0] e48_c, e4_c, um_c, vm_c, um5, um6, vm5, vm6;
  logic        un_c, vn_c, un5, un6, un7, un8, vn5, vn6, vn7, vn8;
  logic [2:0][55:0] f_pl, f_ph;
  logic [2:0]       f_z, f_inf, f_neg, g_neg;
  logic [2:0][47:0] g_mag, mag_c;
  logic signed [57:0] e9, epre_c;
  logic signed [47:0] e10, e10_c;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = !skid_v;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_same_one <= PAIR_RESET;
      pair_same_two <= PAIR_RESET;
      pair_mixed    <= PAIR_RESET;
      box           <= {BOX_RESET, BOX_RESET, BOX_RESET};
      cutoff_sq     <= CUTOFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAIR_SAME_ONE: pair_same_one <= cfg_data;
        REG_PAIR_SAME_TWO: pair_same_two <= cfg_data;
        REG_PAIR_MIXED:    pair_mixed    <= cfg_data;
        REG_BOX_X:         box[0]        <= cfg_data[31:0];
        REG_BOX_Y:         box[1]        <= cfg_data[31:0];
        REG_BOX_Z:         box[2]        <= cfg_data[31:0];
        REG_CUTOFF_SQ:     cutoff_sq     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The skid register catches an item that arrives while the pipeline is held; it is
  // drained first once the pipeline moves again.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en) begin
      skid_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && in_ready) begin
      sk_ta <= a_type;
      sk_tb <= b_type;
      sk_a  <= {a_z, a_y, a_x};
      sk_b  <= {b_z, b_y, b_x};
    end
  end

  always_comb begin
    if (skid_v) begin
      src_v  = 1'b1;
      src_ta = sk_ta;
      src_tb = sk_tb;
      src_a  = sk_a;
      src_b  = sk_b;
    end else begin
      src_v  = in_valid;
      src_ta = a_type;
      src_tb = b_type;
      src_a  = {a_z, a_y, a_x};
      src_b  = {b_z, b_y, b_x};
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[N_VLD-2:0], src_v};
      out_valid <= vld[N_VLD-1];
    end
  end

  // Stage 1: raw deltas and the half-box comparisons, done as 2d against L.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = {2'b00, src_a[i]} - {2'b00, src_b[i]};
      ge_c[i] = $signed({diff_c[i][33], diff_c[i], 1'b0}) >= $signed({4'b0, box[i]});
      le_c[i] = $signed({diff_c[i][33], diff_c[i], 1'b0}) <= -$signed({4'b0, box[i]});
    end
  end

  // Stage 2: wrap once; stage 3: far test and squares.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s1_ge[i]) begin
        dw_c[i] = s1_d[i] - {2'b00, box[i]};
      end else if (s1_le[i]) begin
        dw_c[i] = s1_d[i] + {2'b00, box[i]};
      end else begin
        dw_c[i] = s1_d[i];
      end
      far_c[i] = ($signed(s2_d[i]) >= FAR_DELTA) || ($signed(s2_d[i]) <= -FAR_DELTA);
      sq_c[i]  = 48'($signed(s2_d[i][24:0])) * 48'($signed(s2_d[i][24:0]));
    end
  end

  // Stage 4: squared distance, cutoff and parameter selection.
  always_comb begin
    r2_c = 50'(s3_sq[0]) + 50'(s3_sq[1]) + 50'(s3_sq[2]);
    if (s3_ta == s3_tb) begin
      prm_c = s3_ta ? pair_same_two : pair_same_one;
    end else begin
      prm_c = pair_mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta  <= src_ta;
      s1_tb  <= src_tb;
      s1_d   <= diff_c;
      s1_ge  <= ge_c;
      s1_le  <= le_c;
      s2_ta  <= s1_ta;
      s2_tb  <= s1_tb;
      s2_d   <= dw_c;
      s3_ta  <= s2_ta;
      s3_tb  <= s2_tb;
      s3_far <= |far_c;
      s3_sq  <= sq_c;
      s3_d   <= {s2_d[2][24:0], s2_d[1][24:0], s2_d[0][24:0]};
      sdl[0].ta    <= s3_ta;
      sdl[0].tb    <= s3_tb;
      sdl[0].inr   <= !s3_far && (r2_c <= {2'b00, cutoff_sq, 16'b0});
      sdl[0].d     <= s3_d;
      sdl[0].eps   <= prm_c[47:32];
      sdl[0].shift <= prm_c[15:0];
      r2_4   <= r2_c[47:0];
      sig2_4 <= prm_c[31:16];
      // Divider entry. The quotient reaches 2^64 exactly when r2 * 256 <= sigma squared.
      div[0].rem  <= {40'b0, sig2_4[15:8]};
      div[0].nb   <= sig2_4[7:0];
      div[0].q    <= '0;
      div[0].r2   <= r2_4;
      div[0].sat  <= r2_4 <= {40'b0, sig2_4[15:8]};
      div[0].zero <= sig2_4 == '0;
    end
  end

  for (genvar k = 1; k < N_SIDE; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sdl[k] <= sdl[k-1];
      end
    end
  end

  // Restoring divider for sigma2 * 2^56 / r2, two quotient bits per stage. The numerator
  // bits below the first eight are zero, so they shift in from nb as it empties.
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [48:0] ra, rb;
    logic        ga, gb;
    logic [47:0] rma, rmb;

    always_comb begin
      ra  = {div[j-1].rem, div[j-1].nb[7]};
      ga  = ra >= {1'b0, div[j-1].r2};
      rma = ga ? 48'(ra - {1'b0, div[j-1].r2}) : ra[47:0];
      rb  = {rma, div[j-1].nb[6]};
      gb  = rb >= {1'b0, div[j-1].r2};
      rmb = gb ? 48'(rb - {1'b0, div[j-1].r2}) : rb[47:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div[j].rem  <= rmb;
        div[j].nb   <= {div[j-1].nb[5:0], 2'b00};
        div[j].q    <= {div[j-1].q[61:0], ga, gb};
        div[j].r2   <= div[j-1].r2;
        div[j].sat  <= div[j-1].sat;
        div[j].zero <= div[j-1].zero;
      end
    end
  end

  // r2i, then r6i = r2i^3; in parallel 48*eps*r2i. After r6i come the signed
  // differences r6i - 0.5 and r6i - 1, then the last products.
  always_comb begin
    e48_c = {18'b0, 22'(sdl[34].eps) * 22'd48, 24'b0};
    e4_c  = {22'b0, sdl[38].eps, 26'b0};
    un_c  = 1'b0;
    vn_c  = 1'b0;
    if (r6i == QSAT) begin
      um_c = QSAT;
      vm_c = QSAT;
    end else begin
      if (r6i >= Q_HALF) begin
        um_c = r6i - Q_HALF;
      end else begin
        um_c = Q_HALF - r6i;
        un_c = 1'b1;
      end
      if (r6i >= Q_ONE) begin
        vm_c = r6i - Q_ONE;
      end else begin
        vm_c = Q_ONE - r6i;
        vn_c = 1'b1;
      end
    end
  end

  ljpf_qmul u_sq  (.clk(clk), .en(en), .a(r2i0),  .b(r2i0), .p(a1));
  ljpf_qmul u_e48 (.clk(clk), .en(en), .a(e48_c), .b(r2i0), .p(t1));
  ljpf_qmul u_r6  (.clk(clk), .en(en), .a(a1),    .b(r2i2), .p(r6i));
  ljpf_qmul u_t2  (.clk(clk), .en(en), .a(t1_4),  .b(r6i),  .p(t2));
  ljpf_qmul u_e4  (.clk(clk), .en(en), .a(e4_c),  .b(r6i),  .p(e4r6));
  ljpf_qmul u_ff  (.clk(clk), .en(en), .a(t2),    .b(um6),  .p(ff));
  ljpf_qmul u_en  (.clk(clk), .en(en), .a(e4r6),  .b(vm6),  .p(en8));

  // Force magnitude: ff * |d| >> 24, held at 2^47. Energy: magnitude >> 8, signed,
  // minus the shift in Q24.24, then clamped.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = 48'((({f_ph[i], 32'b0} + {32'b0, f_pl[i]}) >> 24));
      if (f_z[i]) begin
        mag_c[i] = '0;
      end else if (f_inf[i] ||
                   (64'((({f_ph[i], 32'b0} + {32'b0, f_pl[i]}) >> 24)) > FORCE_LIM)) begin
        mag_c[i] = FORCE_LIM[47:0];
      end
    end
    epre_c = $signed({2'b00, en8[63:8]});
    if (vn8) begin
      epre_c = -epre_c;
    end
    if (e9 > E_MAX) begin
      e10_c = E_MAX[47:0];
    end else if (e9 < E_MIN) begin
      e10_c = E_MIN[47:0];
    end else begin
      e10_c = e9[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2i0 <= div[DIV_STAGES].zero ? '0 : (div[DIV_STAGES].sat ? QSAT : div[DIV_STAGES].q);
      r2i1 <= r2i0;
      r2i2 <= r2i1;
      t1_3 <= t1;
      t1_4 <= t1_3;
      um5  <= um_c;
      um6  <= um5;
      vm5  <= vm_c;
      vm6  <= vm5;
      un5  <= un_c;
      un6  <= un5;
      un7  <= un6;
      un8  <= un7;
      vn5  <= vn_c;
      vn6  <= vn5;
      vn7  <= vn6;
      vn8  <= vn7;
      for (int i = 0; i < 3; i++) begin
        f_pl[i]  <= 56'(ff[31:0]) * 56'(25'(-$signed(sdl[42].d[i]) < 0 ?
                    sdl[42].d[i] : -$signed(sdl[42].d[i])));
        f_ph[i]  <= 56'(ff[63:32]) * 56'(25'($signed(sdl[42].d[i]) < 0 ?
                    -$signed(sdl[42].d[i]) : sdl[42].d[i]));
        f_z[i]   <= (ff == '0) || (sdl[42].d[i] == '0);
        f_inf[i] <= ff == QSAT;
        f_neg[i] <= un8 ^ sdl[42].d[i][24];
        g_mag[i] <= mag_c[i];
        g_neg[i] <= f_neg[i];
      end
      e9  <= epre_c - $signed({{26{sdl[42].shift[15]}}, sdl[42].shift, 16'b0});
      e10 <= e10_c;
    end
  end

  // Output register: gate by range and by the type-1 against type-2 rule.
  always_ff @(posedge clk) begin
    if (en) begin
      in_range    <= sdl[44].inr;
      pair_energy <= sdl[44].inr ? e10 : '0;
      force_x     <= '0;
      force_y     <= '0;
      force_z     <= '0;
      if (sdl[44].inr && !sdl[44].ta && sdl[44].tb) begin
        force_x <= (!g_neg[0] && g_mag[0] > OUT_MAX) ? OUT_MAX :
                   (g_neg[0] ? -g_mag[0] : g_mag[0]);
        force_y <= (!g_neg[1] && g_mag[1] > OUT_MAX) ? OUT_MAX :
                   (g_neg[1] ? -g_mag[1] : g_mag[1]);
        force_z <= (!g_neg[2] && g_mag[2] > OUT_MAX) ? OUT_MAX :
                   (g_neg[2] ? -g_mag[2] : g_mag[2]);
      end
    end
  end

endmodule

### rtl/ljpf_qmul.sv
// Two-stage saturating Q32.32 multiplier with infinity handling.
// Depends on ljpf_pkg for the saturation constant.
module ljpf_qmul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  import ljpf_pkg::*;

  logic [63:0]  ll, lh, hl, hh;
  logic         zr, inf;
  logic [127:0] full;
  logic [63:0]  res;

  // Four 32 x 32 partial products are registered first.
  always_ff @(posedge clk) begin
    if (en) begin
      ll  <= 64'(a[31:0]) * 64'(b[31:0]);
      lh  <= 64'(a[31:0]) * 64'(b[63:32]);
      hl  <= 64'(a[63:32]) * 64'(b[31:0]);
      hh  <= 64'(a[63:32]) * 64'(b[63:32]);
      zr  <= (a == '0) || (b == '0);
      inf <= (a == QSAT) || (b == QSAT);
      p   <= res;
    end
  end

  always_comb begin
    full = {hh, 64'b0} + {32'b0, lh, 32'b0} + {32'b0, hl, 32'b0} + {64'b0, ll};
    if (zr) begin
      res = '0;
    end else if (inf || (full[127:96] != '0)) begin
      res = QSAT;
    end else begin
      res = full[95:32];
    end
  end

endmodule
